// ===== sv/trst_pkg.sv =====
// shared types and constants of the touch report slot tracker
package trst_pkg;

    localparam int SLOTS        = 10;
    localparam int REPORT_BYTES = 27;
    localparam int MAX_TOUCHES  = 5;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_W  = 5;
    localparam int REC_W  = 3;
    localparam int OFF_W  = 3;

    // record layout: four position bytes then the id byte
    localparam logic [OFF_W-1:0] OFF_ID = 3'd4;

    localparam logic [1:0] MARK_IDLE     = 2'd0;
    localparam logic [1:0] MARK_FRESH    = 2'd1;
    localparam logic [1:0] MARK_REPORTED = 2'd2;

    localparam logic [1:0] ACT_CONTACT = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_SYNC    = 2'd2;

    typedef struct packed {
        logic take;
        logic walk_clr;
        logic emit_contact;
        logic emit_release;
        logic emit_sync;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic       frame_end;
        logic [1:0] mark;
        logic       walk_last;
        logic       out_free;
    } t_sts;

endpackage

// ===== sv/touch_report_slot_tracker.sv =====
// top level of the touch report slot tracker
//
// takes a touch report one byte per request and tracks up to ten contact slots
// in multitouch type b style. a report is 27 bytes: byte 0 holds the touch
// count (low 3 bits, capped at 5), and from byte 2 on come five-byte records
// of x (little-endian), y (little-endian) and an id byte that picks the slot.
// i_frame_start resyncs the byte position to byte 0; without it the position
// wraps after the last byte. ids whose slot falls outside the ten slots are
// dropped. a record is applied to its slot when its id byte arrives. on the
// last byte of a report the controller walks the slots one per cycle,
// emitting a contact for every fresh slot and a release for every reported
// slot that was not refreshed, then a sync result with o_last_of_run set; a
// walk step that emits waits while the single output register is still held
// by the consumer. input is not taken during the walk and the sync.
module touch_report_slot_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_slot_number,
    output logic [1:0]  o_action,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic        o_last_of_run
);

    trst_pkg::t_cmd cmd;
    trst_pkg::t_sts sts;

    // sequencer: idle intake, slot walk, sync
    trst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // parsing, slot state and the output register
    trst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_slot_number (o_slot_number),
        .o_action      (o_action),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== sv/trst_ctrl.sv =====
// controller: byte intake and end-of-report slot walk sequencing
module trst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  trst_pkg::t_sts i_sts,
    output trst_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_SYNC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.frame_end) begin
                        o_cmd.walk_clr = 1'b1;
                        n_state        = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                case (i_sts.mark)
                    trst_pkg::MARK_FRESH: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit_contact = 1'b1;
                            o_cmd.advance      = 1'b1;
                        end
                    end
                    trst_pkg::MARK_REPORTED: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit_release = 1'b1;
                            o_cmd.advance      = 1'b1;
                        end
                    end
                    default: o_cmd.advance = 1'b1;
                endcase
                if (o_cmd.advance && i_sts.walk_last) begin
                    n_state = ST_SYNC;
                end
            end
            ST_SYNC: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sync = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/trst_dp.sv =====
// datapath: byte parsing, slot storage, walk index and output register
module trst_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_data_byte,
    input  logic           i_frame_start,
    input  trst_pkg::t_cmd i_cmd,
    output trst_pkg::t_sts o_sts,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [3:0]     o_slot_number,
    output logic [1:0]     o_action,
    output logic [15:0]    o_pos_x,
    output logic [15:0]    o_pos_y,
    output logic           o_last_of_run
);

    localparam int SLOT_W = trst_pkg::SLOT_W;
    localparam int POS_W  = trst_pkg::POS_W;
    localparam int REC_W  = trst_pkg::REC_W;
    localparam int OFF_W  = trst_pkg::OFF_W;

    logic [1:0]        r_mark [trst_pkg::SLOTS];
    logic [15:0]       r_x    [trst_pkg::SLOTS];
    logic [15:0]       r_y    [trst_pkg::SLOTS];
    logic [POS_W-1:0]  r_pos;
    logic [REC_W-1:0]  r_count;
    logic [REC_W-1:0]  r_rec;
    logic [OFF_W-1:0]  r_off;
    logic [31:0]       r_asm;
    logic [SLOT_W-1:0] r_widx;
    logic              r_out_valid;
    logic [3:0]        r_out_slot;
    logic [1:0]        r_out_act;
    logic [15:0]       r_out_x;
    logic [15:0]       r_out_y;
    logic              r_out_last;

    logic [POS_W-1:0] pos_eff;
    logic             frame_end;
    logic [2:0]       cnt_raw;
    logic [3:0]       id_slot;
    logic             rec_live;
    logic             apply;
    logic             out_free;
    logic             emit_any;

    always_comb begin
        if (i_frame_start || ({1'b0, r_pos} >= 6'(trst_pkg::REPORT_BYTES))) begin
            pos_eff = '0;
        end else begin
            pos_eff = r_pos;
        end
        frame_end = (pos_eff == POS_W'(trst_pkg::REPORT_BYTES - 1));
        cnt_raw   = i_data_byte[2:0];
        id_slot   = {i_data_byte[2:0], i_data_byte[3]};
        rec_live  = (pos_eff >= POS_W'(2)) && (r_rec < r_count);
        apply     = i_cmd.take && rec_live && (r_off == trst_pkg::OFF_ID)
                    && ({1'b0, id_slot} < 5'(trst_pkg::SLOTS));
        out_free  = !r_out_valid || i_out_ready;
        emit_any  = i_cmd.emit_contact || i_cmd.emit_release || i_cmd.emit_sync;
    end

    assign o_sts.frame_end = frame_end;
    assign o_sts.mark      = r_mark[r_widx];
    assign o_sts.walk_last = (r_widx == SLOT_W'(trst_pkg::SLOTS - 1));
    assign o_sts.out_free  = out_free;

    // byte position and record counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_rec   <= '0;
            r_off   <= '0;
        end else if (i_cmd.take) begin
            r_pos <= frame_end ? '0 : pos_eff + POS_W'(1);
            if (pos_eff == '0) begin
                r_count <= (cnt_raw > REC_W'(trst_pkg::MAX_TOUCHES))
                           ? REC_W'(trst_pkg::MAX_TOUCHES) : cnt_raw;
            end
            if (pos_eff < POS_W'(2)) begin
                r_rec <= '0;
                r_off <= '0;
            end else if (r_off == trst_pkg::OFF_ID) begin
                r_rec <= r_rec + REC_W'(1);
                r_off <= '0;
            end else begin
                r_off <= r_off + OFF_W'(1);
            end
        end
    end

    // record assembly, little-endian x then y
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && rec_live) begin
            case (r_off)
                3'd0:    r_asm[7:0]   <= i_data_byte;
                3'd1:    r_asm[15:8]  <= i_data_byte;
                3'd2:    r_asm[23:16] <= i_data_byte;
                3'd3:    r_asm[31:24] <= i_data_byte;
                default: r_asm        <= r_asm;
            endcase
        end
    end

    // slot marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < trst_pkg::SLOTS; i++) begin
                r_mark[i] <= trst_pkg::MARK_IDLE;
            end
        end else if (apply) begin
            r_mark[id_slot[SLOT_W-1:0]] <= trst_pkg::MARK_FRESH;
        end else if (i_cmd.emit_contact) begin
            r_mark[r_widx] <= trst_pkg::MARK_REPORTED;
        end else if (i_cmd.emit_release) begin
            r_mark[r_widx] <= trst_pkg::MARK_IDLE;
        end
    end

    // slot positions
    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_x[id_slot[SLOT_W-1:0]] <= r_asm[15:0];
            r_y[id_slot[SLOT_W-1:0]] <= r_asm[31:16];
        end
    end

    // walk index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
        end else if (i_cmd.walk_clr) begin
            r_widx <= '0;
        end else if (i_cmd.advance && !o_sts.walk_last) begin
            r_widx <= r_widx + SLOT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_any) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_any) begin
            r_out_slot <= i_cmd.emit_sync ? 4'd0 : 4'(r_widx);
            r_out_last <= i_cmd.emit_sync;
            if (i_cmd.emit_contact) begin
                r_out_act <= trst_pkg::ACT_CONTACT;
                r_out_x   <= r_x[r_widx];
                r_out_y   <= r_y[r_widx];
            end else begin
                r_out_act <= i_cmd.emit_sync ? trst_pkg::ACT_SYNC : trst_pkg::ACT_RELEASE;
                r_out_x   <= '0;
                r_out_y   <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_number = r_out_slot;
    assign o_action      = r_out_act;
    assign o_pos_x       = r_out_x;
    assign o_pos_y       = r_out_y;
    assign o_last_of_run = r_out_last;

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_any |-> out_free)
        else $error("result loaded over an untaken result");
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx < SLOT_W'(trst_pkg::SLOTS) || trst_pkg::SLOTS == (1 << SLOT_W))
        else $error("walk index beyond slot count");
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < 6'(trst_pkg::REPORT_BYTES))
        else $error("byte position beyond report length");
    a_sync_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_sync |=> (o_out_valid && o_last_of_run && o_action == trst_pkg::ACT_SYNC))
        else $error("sync result not presented as last of run");
    a_no_take_during_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> !emit_any)
        else $error("byte taken while walking slots");
`endif

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the touch report slot tracker: framed bytes in, slot events checked
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one five-byte touch record as it sits in a report
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  id;
    } t_touch_rec;

    // one result of the slot walk
    typedef struct packed {
        logic [3:0]  slot;
        logic [1:0]  act;
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } t_slot_event;

    // one report to send; typed events, where given, replace the predicted walk
    typedef struct packed {
        logic                   sync0;
        logic [4:0]             len;
        logic [7:0]             cnt;
        t_touch_rec [4:0]       recs;
        logic [1:0]             ntyped;
        t_slot_event [2:0]      typed;
    } t_report_row;

    typedef enum {PH_STEADY, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} t_idle_phase;

    localparam int          DIR_ROWS      = 10;
    localparam int          RANDOM_BYTES  = 100;
    localparam int          DRAIN_CYCLES  = 40;
    localparam t_touch_rec  JUNK_REC      = {16'hDEAD, 16'hBEEF, 8'h00};
    localparam t_slot_event NO_EVENT      = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_frame_start;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_slot_number;
    logic [1:0]  o_action;
    logic [15:0] o_pos_x;
    logic [15:0] o_pos_y;
    logic        o_last_of_run;

    // predictor copy of the slot tracker state
    logic [1:0]  mark_q [trst_pkg::SLOTS];
    logic [15:0] slot_x_q [trst_pkg::SLOTS];
    logic [15:0] slot_y_q [trst_pkg::SLOTS];
    logic [4:0]  byte_pos_q;
    logic [2:0]  touch_cnt_q;
    logic [31:0] rec_asm_q;

    t_slot_event walk_events [$];     // events of the latest walk, if any
    t_slot_event pending_events [$];  // events the block still owes us
    t_report_row dir_table [DIR_ROWS];

    t_idle_phase idle_phase;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          mismatches;
    int          bytes_taken;

    touch_report_slot_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_slot_number (o_slot_number),
        .o_action      (o_action),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs or owes results forever
    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic t_touch_rec rec(input logic [15:0] x, input logic [15:0] y,
                                       input logic [7:0] id);
        return {x, y, id};
    endfunction

    // sync is the only event that closes a run
    function automatic t_slot_event ev(input logic [3:0] slot, input logic [1:0] act,
                                       input logic [15:0] x, input logic [15:0] y);
        return {slot, act, x, y, act == trst_pkg::ACT_SYNC};
    endfunction

    function automatic t_report_row row(input logic sync0, input int len, input logic [7:0] cnt,
                                        input t_touch_rec r0, r1, r2, r3, r4,
                                        input int ntyped, input t_slot_event t0, t1, t2);
        t_report_row f;
        f.sync0    = sync0;
        f.len      = 5'(len);
        f.cnt      = cnt;
        f.recs[0]  = r0;
        f.recs[1]  = r1;
        f.recs[2]  = r2;
        f.recs[3]  = r3;
        f.recs[4]  = r4;
        f.ntyped   = 2'(ntyped);
        f.typed[0] = t0;
        f.typed[1] = t1;
        f.typed[2] = t2;
        return f;
    endfunction

    // coordinates lean on the extremes
    function automatic logic [15:0] coord();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // well-formed report with random content; mostly slots that exist
    function automatic t_report_row random_report(input logic sync0, input int len);
        t_report_row f;
        logic [3:0]  sl;
        f.sync0 = sync0;
        f.len   = 5'(len);
        f.cnt   = {5'($urandom), 3'($urandom_range(0, 7))};
        for (int j = 0; j < 5; j++) begin
            sl = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, trst_pkg::SLOTS - 1))
                                              : 4'($urandom_range(0, 15));
            // slot = id[2:0] << 1 | id[3], so invert that mapping
            f.recs[j] = rec(coord(), coord(), {4'($urandom), sl[0], sl[3:1]});
        end
        f.ntyped = 2'd0;
        f.typed  = '0;
        return f;
    endfunction

    function automatic void enter_phase(input int k);
        idle_phase = t_idle_phase'(k % 4);
        case (idle_phase)
            PH_STEADY:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            PH_SRC_IDLE:   begin src_idle_pct = 83; sink_stall_pct = 0;  end
            PH_SINK_STALL: begin src_idle_pct = 0;  sink_stall_pct = 83; end
            default:       begin src_idle_pct = 22; sink_stall_pct = 22; end
        endcase
    endfunction

    // predictor: fold one accepted byte into the slot state, walk on the last byte
    task automatic track_byte(input logic [7:0] b, input logic s);
        int         p;
        int         rel;
        int         rn;
        int         off;
        logic [3:0] sl;
        walk_events.delete();
        p = s ? 0 : int'(byte_pos_q);
        if (p >= trst_pkg::REPORT_BYTES)
            p = 0;
        if (p == 0) begin
            touch_cnt_q = (b[2:0] > trst_pkg::MAX_TOUCHES) ? 3'(trst_pkg::MAX_TOUCHES)
                                                            : b[2:0];
        end else if (p >= 2) begin
            rel = p - 2;
            rn  = rel / 5;
            off = rel % 5;
            if (rn < touch_cnt_q) begin
                if (off < trst_pkg::OFF_ID) begin
                    rec_asm_q[off*8 +: 8] = b;
                end else begin
                    sl = {b[2:0], b[3]};
                    // slots past the table are dropped
                    if (sl < trst_pkg::SLOTS) begin
                        mark_q[sl]   = trst_pkg::MARK_FRESH;
                        slot_x_q[sl] = rec_asm_q[15:0];
                        slot_y_q[sl] = rec_asm_q[31:16];
                    end
                end
            end
        end
        if (p == trst_pkg::REPORT_BYTES - 1) begin
            byte_pos_q = '0;
            for (int i = 0; i < trst_pkg::SLOTS; i++) begin
                case (mark_q[i])
                    trst_pkg::MARK_FRESH: begin
                        walk_events.push_back(ev(4'(i), trst_pkg::ACT_CONTACT,
                                                 slot_x_q[i], slot_y_q[i]));
                        mark_q[i] = trst_pkg::MARK_REPORTED;
                    end
                    trst_pkg::MARK_REPORTED: begin
                        walk_events.push_back(ev(4'(i), trst_pkg::ACT_RELEASE,
                                                 16'h0, 16'h0));
                        mark_q[i] = trst_pkg::MARK_IDLE;
                    end
                    default: ;
                endcase
            end
            walk_events.push_back(ev(4'h0, trst_pkg::ACT_SYNC, 16'h0, 16'h0));
        end else begin
            byte_pos_q = 5'(p + 1);
        end
    endtask

    // drive one byte request; entered and left just after a falling edge
    task automatic push_byte(input logic [7:0] b, input logic s, input int ntyped,
                             input t_slot_event [2:0] typed);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_data_byte   = b;
        i_frame_start = s;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_taken++;
        track_byte(b, s);
        if (ntyped != 0 && walk_events.size() != 0) begin
            for (int i = 0; i < ntyped; i++)
                pending_events.push_back(typed[i]);
        end else begin
            foreach (walk_events[i])
                pending_events.push_back(walk_events[i]);
        end
        @(negedge i_clk);
    endtask

    // lay a report out byte by byte; byte 1 is unused filler
    task automatic send_report(input t_report_row f);
        logic [31:0] xy;
        logic [7:0]  b;
        int          rel;
        for (int i = 0; i < f.len; i++) begin
            if (i == 0) begin
                b = f.cnt;
            end else if (i == 1) begin
                b = 8'($urandom);
            end else begin
                rel = i - 2;
                xy  = {f.recs[rel/5].y, f.recs[rel/5].x};
                b   = (rel % 5 == trst_pkg::OFF_ID) ? f.recs[rel/5].id
                                                    : xy[(rel % 5)*8 +: 8];
            end
            push_byte(b, (i == 0) && f.sync0, (i == f.len - 1) ? f.ntyped : 0, f.typed);
        end
    endtask

    // the result side stalls according to the current phase
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // every accepted result must match the oldest outstanding event
    always @(posedge i_clk) begin : result_check
        t_slot_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                mismatches++;
                $display("%0t ns: expected no result, actual slot %h action %h x %h y %h last %b",
                         $time, o_slot_number, o_action, o_pos_x, o_pos_y, o_last_of_run);
            end else begin
                want = pending_events.pop_front();
                check_field("slot_number", 16'(want.slot), 16'(o_slot_number));
                check_field("action", 16'(want.act), 16'(o_action));
                check_field("pos_x", want.x, o_pos_x);
                check_field("pos_y", want.y, o_pos_y);
                check_field("last_of_run", 16'(want.last), 16'(o_last_of_run));
            end
        end
    end

    initial begin
        int start_count;
        int k;
        int n;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = 8'h00;
        i_frame_start = 1'b0;
        mismatches    = 0;
        bytes_taken   = 0;
        enter_phase(0);

        for (int i = 0; i < trst_pkg::SLOTS; i++) begin
            mark_q[i]   = trst_pkg::MARK_IDLE;
            slot_x_q[i] = '0;
            slot_y_q[i] = '0;
        end
        byte_pos_q  = '0;
        touch_cnt_q = '0;
        rec_asm_q   = '0;

        // directed reports
        // empty report straight after reset: records past the count are ignored
        dir_table[0] = row(1'b1, 27, 8'h00, JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC,
                           1, ev(4'd0, trst_pkg::ACT_SYNC, 16'h0, 16'h0), NO_EVENT, NO_EVENT);
        // single contact at the far corner
        dir_table[1] = row(1'b1, 27, 8'h01, rec(16'hFFFF, 16'hFFFF, 8'h00),
                           JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC,
                           2, ev(4'd0, trst_pkg::ACT_CONTACT, 16'hFFFF, 16'hFFFF),
                           ev(4'd0, trst_pkg::ACT_SYNC, 16'h0, 16'h0), NO_EVENT);
        // slot 0 drops out, slot 3 at the origin
        dir_table[2] = row(1'b1, 27, 8'h01, rec(16'h0000, 16'h0000, 8'h09),
                           JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC,
                           3, ev(4'd0, trst_pkg::ACT_RELEASE, 16'h0, 16'h0),
                           ev(4'd3, trst_pkg::ACT_CONTACT, 16'h0, 16'h0),
                           ev(4'd0, trst_pkg::ACT_SYNC, 16'h0, 16'h0));
        // count 7 capped at 5; slots 10 and 15 dropped; slot 1 written twice
        dir_table[3] = row(1'b1, 27, 8'hFF, rec(16'h1111, 16'h2222, 8'h05),
                           rec(16'h3333, 16'h4444, 8'h0F), rec(16'h5555, 16'h6666, 8'h08),
                           rec(16'h7777, 16'h8888, 8'hF8), rec(16'h9999, 16'hAAAA, 8'h84),
                           0, NO_EVENT, NO_EVENT, NO_EVENT);
        // count 6 capped at 5, all slots in range
        dir_table[4] = row(1'b1, 27, 8'h06, rec(16'h0102, 16'h0304, 8'h01),
                           rec(16'h1020, 16'h3040, 8'h02), rec(16'hF00F, 16'h0FF0, 8'h03),
                           rec(16'h8000, 16'h7FFF, 8'h0C), rec(16'h00FF, 16'hFF00, 8'h0B),
                           0, NO_EVENT, NO_EVENT, NO_EVENT);
        // report cut short after two records, then resync
        dir_table[5] = row(1'b1, 12, 8'h02, rec(16'h0102, 16'h0304, 8'h00),
                           rec(16'h0506, 16'h0708, 8'h0A), JUNK_REC, JUNK_REC, JUNK_REC,
                           0, NO_EVENT, NO_EVENT, NO_EVENT);
        // empty report still reports what the cut report applied
        dir_table[6] = row(1'b1, 27, 8'h00, JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC,
                           0, NO_EVENT, NO_EVENT, NO_EVENT);
        // no frame start: position wrapped to byte 0 on its own
        dir_table[7] = row(1'b0, 27, 8'h03, rec(16'h8001, 16'h7FFE, 8'h10),
                           rec(16'h00FF, 16'hFF00, 8'h44), rec(16'h1357, 16'h2468, 8'h0E),
                           JUNK_REC, JUNK_REC, 0, NO_EVENT, NO_EVENT, NO_EVENT);
        dir_table[8] = row(1'b1, 27, 8'h00, JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC,
                           0, NO_EVENT, NO_EVENT, NO_EVENT);
        // high count bits set but count zero, all slots idle by now
        dir_table[9] = row(1'b1, 27, 8'hF8, JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC, JUNK_REC,
                           1, ev(4'd0, trst_pkg::ACT_SYNC, 16'h0, 16'h0), NO_EVENT, NO_EVENT);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            enter_phase(r);
            send_report(dir_table[r]);
        end

        // hold off the sender until the block has caught up completely
        i_in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(negedge i_clk);

        // random part: mostly whole reports, some cut short, some line noise
        start_count = bytes_taken;
        k = 0;
        while (bytes_taken - start_count < RANDOM_BYTES) begin
            enter_phase(k / 2);
            n = $urandom_range(0, 99);
            if (n < 75) begin
                send_report(random_report($urandom_range(0, 4) != 0, trst_pkg::REPORT_BYTES));
            end else if (n < 87) begin
                send_report(random_report(1'b1, $urandom_range(1, trst_pkg::REPORT_BYTES - 1)));
            end else begin
                repeat ($urandom_range(1, 40))
                    push_byte(8'($urandom), $urandom_range(0, 7) == 0, 0, '0);
            end
            k++;
        end

        // let the last walk finish and catch anything extra
        i_in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_events.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
